FILE: rtl/sfl_pkg.sv
// Shared constants, types and the exp table of the sigmoid focal-loss gradient unit.
`default_nettype none
package sfl_pkg;

    localparam int IB = 28;              // internal fraction bits
    localparam int MW = 33;              // shared multiplier operand width
    localparam int PW = 2 * MW;          // product width

    localparam logic [IB:0]   ONE_Q = 29'h1000_0000;
    localparam logic [IB-1:0] LN2_Q = 28'd186065280;
    localparam logic [4:0]    LAST_STEP = 5'd28;

    typedef struct packed {
        logic [15:0] gamma;
        logic [24:0] grad_scale;
        logic [24:0] loss_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        CFG_GAMMA      = 2'd0,
        CFG_GRAD_SCALE = 2'd1,
        CFG_LOSS_SCALE = 2'd2
    } cfg_idx_t;

    // Straight-line multiply program after the logs and powers
    localparam logic [3:0] OP_P_NP   = 4'd0;
    localparam logic [3:0] OP_CP_G   = 4'd1;
    localparam logic [3:0] OP_Q_NQ   = 4'd2;
    localparam logic [3:0] OP_CN_G   = 4'd3;
    localparam logic [3:0] OP_WP_CP  = 4'd4;
    localparam logic [3:0] OP_Y_A    = 4'd5;
    localparam logic [3:0] OP_WN_CN  = 4'd6;
    localparam logic [3:0] OP_YN_B   = 4'd7;
    localparam logic [3:0] OP_GRAD   = 4'd8;
    localparam logic [3:0] OP_WP_NP  = 4'd9;
    localparam logic [3:0] OP_Y_LP   = 4'd10;
    localparam logic [3:0] OP_WN_NQ  = 4'd11;
    localparam logic [3:0] OP_YN_LQ  = 4'd12;
    localparam logic [3:0] OP_BL_LO  = 4'd13;
    localparam logic [3:0] OP_BL_HI  = 4'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_WB,
        ST_LN_MUL,
        ST_LN_WB,
        ST_G_MUL,
        ST_G_WB,
        ST_PW_MUL,
        ST_PW_WB,
        ST_OP_MUL,
        ST_OP_WB,
        ST_DONE
    } state_t;

    typedef logic [IB:0] exp_tab_t [0:IB];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry i = 2^(-2^-i) in Q28 for i >= 1; entry 0 = 1.0
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t   tab;
        logic [63:0] prev;
        tab[0] = ONE_Q;
        prev = isqrt64(64'(ONE_Q >> 1) << IB);
        tab[1] = prev[IB:0];
        for (int i = 2; i <= IB; i++) begin
            prev = isqrt64(prev << IB);
            tab[i] = prev[IB:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

FILE: rtl/sfl_mul.sv
// Shared unsigned multiplier with registered product.
`default_nettype none
module sfl_mul #(
    parameter int W = 33
) (
    input  wire logic             aclk,
    input  wire logic [W-1:0]     a,
    input  wire logic [W-1:0]     b,
    output logic      [2*W-1:0]   prod
);

    logic [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: rtl/sfl_core.sv
// Sequencer and datapath: logs, powers, gradient, loss and batch sum over one multiplier.
`default_nettype none
module sfl_core #(
    parameter int FRAC_BITS         = 16,
    parameter int MAX_ELEMENTS_LOG2 = 20
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire sfl_pkg::cfg_t           cfg,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [FRAC_BITS-1:0]    in_prob,
    input  wire logic [FRAC_BITS:0]      in_targ,
    input  wire logic                    in_last,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [FRAC_BITS+8:0]         out_grad,
    output logic [FRAC_BITS+4:0]         out_eloss,
    output logic [FRAC_BITS+31:0]        out_batch,
    output logic                         out_done
);

    localparam int F    = FRAC_BITS;
    localparam int IB   = sfl_pkg::IB;
    localparam int MW   = sfl_pkg::MW;
    localparam int PW   = sfl_pkg::PW;
    localparam int GW   = F + 9;
    localparam int EW   = F + 5;
    localparam int BW   = F + 32;
    localparam int SW   = F + 5 + MAX_ELEMENTS_LOG2;
    localparam int SW1  = SW + 1;
    localparam int SH_G = 24 + IB - F;
    localparam int SH_E = IB - F;

    localparam logic [PW-1:0] RND28     = PW'(1) << 27;
    localparam logic [PW-1:0] RND24     = PW'(1) << 23;
    localparam logic [PW-1:0] G_HALF    = PW'(1) << (SH_G - 1);
    localparam logic [PW-1:0] G_NEG_LIM = PW'(1) << (GW - 1);
    localparam logic [PW-1:0] G_POS_LIM = G_NEG_LIM - PW'(1);
    localparam logic [PW-1:0] B_MAX     = (PW'(1) << BW) - PW'(1);
    localparam logic [34:0]   E_HALF    = 35'(1) << (SH_E - 1);
    localparam logic [34:0]   E_MAX     = (35'(1) << EW) - 35'(1);
    localparam logic [F:0]    Y_ONE     = (F+1)'(1) << F;

    sfl_pkg::state_t state_reg, state_next;

    logic [IB-1:0] p_reg, p_next, q_reg, q_next;
    logic [IB:0]   y_reg, y_next, yn_reg, yn_next;
    logic          last_reg, last_next;
    logic          sel_reg, sel_next;
    logic [29:0]   m_reg, m_next;
    logic [4:0]    k_reg, k_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [IB-1:0] lg_reg, lg_next;
    logic [32:0]   lp_reg, lp_next, lq_reg, lq_next;
    logic [32:0]   np_reg, np_next, nq_reg, nq_next;
    logic [36:0]   t_reg, t_next;
    logic [IB:0]   r_reg, r_next;
    logic [IB:0]   wp_reg, wp_next, wn_reg, wn_next;
    logic [32:0]   cp_reg, cp_next, cn_reg, cn_next;
    logic [32:0]   tmp_reg, tmp_next;
    logic [32:0]   ta_reg, ta_next, tb_reg, tb_next;
    logic [32:0]   lacc_reg, lacc_next;
    logic [3:0]    op_reg, op_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [GW-1:0] grad_reg, grad_next;
    logic [EW-1:0] eloss_reg, eloss_next;
    logic [BW-1:0] batch_reg, batch_next;
    logic          done_reg, done_next;

    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;

    // datapath helpers
    logic [F-1:0]  praw;
    logic [F:0]    yraw;
    logic [IB-1:0] p_in;
    logic [IB:0]   y_in;
    logic [29:0]   sq_val;
    logic [4:0]    bidx;
    logic [IB-1:0] lg_upd;
    logic [32:0]   l_val;
    logic [PW-1:0] r28;
    logic [IB-1:0] frac;
    logic [IB:0]   r_upd;
    logic [IB:0]   w_val;
    logic          neg;
    logic [32:0]   mag;
    logic [PW-1:0] g_mag, g_clip;
    logic [GW-1:0] grad_val;
    logic [33:0]   loss;
    logic [34:0]   e_full;
    logic [EW-1:0] eloss_val;
    logic [SW1-1:0] s_add;
    logic [PW-1:0] b_sum;

    sfl_mul #(.W(MW)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign praw   = (in_prob == '0) ? F'(1) : in_prob;
    assign yraw   = (in_targ > Y_ONE) ? Y_ONE : in_targ;
    assign p_in   = IB'(praw) << (IB - F);
    assign y_in   = (IB+1)'(yraw) << (IB - F);

    assign sq_val = prod[57:28];
    assign bidx   = sfl_pkg::LAST_STEP - cnt_reg;
    assign lg_upd = sq_val[29] ? (lg_reg | (IB'(1) << bidx)) : lg_reg;
    assign l_val  = {k_reg, {IB{1'b0}}} - {5'b0, lg_upd};

    assign r28    = prod + RND28;
    assign frac   = t_reg[IB-1:0];
    assign r_upd  = frac[bidx] ? r28[56:28] : r_reg;
    assign w_val  = (t_reg[36:28] > 9'd28) ? '0 : (r_upd >> t_reg[32:28]);

    assign neg    = ta_reg > tb_reg;
    assign mag    = neg ? (ta_reg - tb_reg) : (tb_reg - ta_reg);
    assign g_mag  = (prod + G_HALF) >> SH_G;
    assign g_clip = neg ? ((g_mag > G_NEG_LIM) ? G_NEG_LIM : g_mag)
                        : ((g_mag > G_POS_LIM) ? G_POS_LIM : g_mag);
    assign grad_val = neg ? GW'(PW'(0) - g_clip) : GW'(g_clip);

    assign loss      = {1'b0, lacc_reg} + {1'b0, prod[60:28]};
    assign e_full    = (35'(loss) + E_HALF) >> SH_E;
    assign eloss_val = (e_full > E_MAX) ? EW'(E_MAX) : EW'(e_full);
    assign s_add     = SW1'(sum_reg) + SW1'(eloss_val);

    assign b_sum = prod + PW'(tmp_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfl_pkg::ST_IDLE:   if (in_valid) state_next = sfl_pkg::ST_NORM;
            sfl_pkg::ST_NORM:   if (m_reg[29:28] != 2'b00) state_next = sfl_pkg::ST_SQ_MUL;
            sfl_pkg::ST_SQ_MUL: state_next = sfl_pkg::ST_SQ_WB;
            sfl_pkg::ST_SQ_WB: begin
                if (cnt_reg != sfl_pkg::LAST_STEP) state_next = sfl_pkg::ST_SQ_MUL;
                else if (sel_reg) state_next = sfl_pkg::ST_LN_MUL;
                else state_next = sfl_pkg::ST_NORM;
            end
            sfl_pkg::ST_LN_MUL: state_next = sfl_pkg::ST_LN_WB;
            sfl_pkg::ST_LN_WB:  state_next = sel_reg ? sfl_pkg::ST_G_MUL : sfl_pkg::ST_LN_MUL;
            sfl_pkg::ST_G_MUL:  state_next = sfl_pkg::ST_G_WB;
            sfl_pkg::ST_G_WB:   state_next = sfl_pkg::ST_PW_MUL;
            sfl_pkg::ST_PW_MUL: state_next = sfl_pkg::ST_PW_WB;
            sfl_pkg::ST_PW_WB: begin
                if (cnt_reg != sfl_pkg::LAST_STEP) state_next = sfl_pkg::ST_PW_MUL;
                else if (sel_reg) state_next = sfl_pkg::ST_OP_MUL;
                else state_next = sfl_pkg::ST_G_MUL;
            end
            sfl_pkg::ST_OP_MUL: state_next = sfl_pkg::ST_OP_WB;
            sfl_pkg::ST_OP_WB: begin
                if ((op_reg == sfl_pkg::OP_YN_LQ && !last_reg) || op_reg == sfl_pkg::OP_BL_HI)
                    state_next = sfl_pkg::ST_DONE;
                else
                    state_next = sfl_pkg::ST_OP_MUL;
            end
            sfl_pkg::ST_DONE:   if (out_ready) state_next = sfl_pkg::ST_IDLE;
            default:            state_next = sfl_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake and multiplier operands
    always_comb begin
        in_ready  = (state_reg == sfl_pkg::ST_IDLE);
        out_valid = (state_reg == sfl_pkg::ST_DONE);
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            sfl_pkg::ST_SQ_MUL: begin
                mul_a = MW'(m_reg);
                mul_b = MW'(m_reg);
            end
            sfl_pkg::ST_LN_MUL: begin
                mul_a = sel_reg ? lq_reg : lp_reg;
                mul_b = MW'(sfl_pkg::LN2_Q);
            end
            sfl_pkg::ST_G_MUL: begin
                // Wp takes Lq first, Wn takes Lp second
                mul_a = sel_reg ? lp_reg : lq_reg;
                mul_b = MW'(cfg.gamma);
            end
            sfl_pkg::ST_PW_MUL: begin
                mul_a = MW'(r_reg);
                mul_b = MW'(sfl_pkg::EXP_TAB[cnt_reg]);
            end
            sfl_pkg::ST_OP_MUL: begin
                unique case (op_reg)
                    sfl_pkg::OP_P_NP:  begin mul_a = MW'(p_reg);  mul_b = np_reg; end
                    sfl_pkg::OP_CP_G:  begin mul_a = tmp_reg;     mul_b = MW'(cfg.gamma); end
                    sfl_pkg::OP_Q_NQ:  begin mul_a = MW'(q_reg);  mul_b = nq_reg; end
                    sfl_pkg::OP_CN_G:  begin mul_a = tmp_reg;     mul_b = MW'(cfg.gamma); end
                    sfl_pkg::OP_WP_CP: begin mul_a = MW'(wp_reg); mul_b = cp_reg; end
                    sfl_pkg::OP_Y_A:   begin mul_a = MW'(y_reg);  mul_b = tmp_reg; end
                    sfl_pkg::OP_WN_CN: begin mul_a = MW'(wn_reg); mul_b = cn_reg; end
                    sfl_pkg::OP_YN_B:  begin mul_a = MW'(yn_reg); mul_b = tmp_reg; end
                    sfl_pkg::OP_GRAD:  begin mul_a = mag;  mul_b = MW'(cfg.grad_scale); end
                    sfl_pkg::OP_WP_NP: begin mul_a = MW'(wp_reg); mul_b = np_reg; end
                    sfl_pkg::OP_Y_LP:  begin mul_a = MW'(y_reg);  mul_b = tmp_reg; end
                    sfl_pkg::OP_WN_NQ: begin mul_a = MW'(wn_reg); mul_b = nq_reg; end
                    sfl_pkg::OP_YN_LQ: begin mul_a = MW'(yn_reg); mul_b = tmp_reg; end
                    sfl_pkg::OP_BL_LO: begin
                        mul_a = MW'(sum_reg[23:0]);
                        mul_b = MW'(cfg.loss_scale);
                    end
                    sfl_pkg::OP_BL_HI: begin
                        mul_a = MW'(sum_reg >> 24);
                        mul_b = MW'(cfg.loss_scale);
                    end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // register updates
    always_comb begin
        p_next = p_reg;       q_next = q_reg;       y_next = y_reg;     yn_next = yn_reg;
        last_next = last_reg; sel_next = sel_reg;   m_next = m_reg;     k_next = k_reg;
        cnt_next = cnt_reg;   lg_next = lg_reg;     lp_next = lp_reg;   lq_next = lq_reg;
        np_next = np_reg;     nq_next = nq_reg;     t_next = t_reg;     r_next = r_reg;
        wp_next = wp_reg;     wn_next = wn_reg;     cp_next = cp_reg;   cn_next = cn_reg;
        tmp_next = tmp_reg;   ta_next = ta_reg;     tb_next = tb_reg;   lacc_next = lacc_reg;
        op_next = op_reg;     sum_next = sum_reg;   grad_next = grad_reg;
        eloss_next = eloss_reg; batch_next = batch_reg; done_next = done_reg;

        unique case (state_reg)
            sfl_pkg::ST_IDLE: begin
                if (in_valid) begin
                    p_next    = p_in;
                    q_next    = IB'(sfl_pkg::ONE_Q - (IB+1)'(p_in));
                    y_next    = y_in;
                    yn_next   = sfl_pkg::ONE_Q - y_in;
                    last_next = in_last;
                    m_next    = 30'(p_in);
                    k_next    = '0;
                    sel_next  = 1'b0;
                end
            end
            sfl_pkg::ST_NORM: begin
                // one bit per cycle until the mantissa reaches [1,2)
                if (m_reg[29:28] == 2'b00) begin
                    m_next = {m_reg[28:0], 1'b0};
                    k_next = k_reg + 5'd1;
                end else begin
                    cnt_next = 5'd1;
                    lg_next  = '0;
                end
            end
            sfl_pkg::ST_SQ_WB: begin
                lg_next = lg_upd;
                m_next  = sq_val[29] ? {1'b0, sq_val[29:1]} : sq_val;
                if (cnt_reg == sfl_pkg::LAST_STEP) begin
                    if (sel_reg) begin
                        lq_next  = l_val;
                        sel_next = 1'b0;
                    end else begin
                        lp_next  = l_val;
                        sel_next = 1'b1;
                        m_next   = 30'(q_reg);
                        k_next   = '0;
                    end
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            sfl_pkg::ST_LN_WB: begin
                if (sel_reg) nq_next = r28[60:28];
                else         np_next = r28[60:28];
                sel_next = ~sel_reg;
            end
            sfl_pkg::ST_G_WB: begin
                t_next   = prod[48:12];
                r_next   = sfl_pkg::ONE_Q;
                cnt_next = 5'd1;
            end
            sfl_pkg::ST_PW_WB: begin
                r_next = r_upd;
                if (cnt_reg == sfl_pkg::LAST_STEP) begin
                    if (sel_reg) wn_next = w_val;
                    else         wp_next = w_val;
                    sel_next = ~sel_reg;
                    op_next  = sfl_pkg::OP_P_NP;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            sfl_pkg::ST_OP_WB: begin
                op_next = op_reg + 4'd1;
                unique case (op_reg)
                    sfl_pkg::OP_P_NP:  tmp_next = prod[60:28];
                    sfl_pkg::OP_CP_G:  cp_next  = 33'(q_reg) + prod[44:12];
                    sfl_pkg::OP_Q_NQ:  tmp_next = prod[60:28];
                    sfl_pkg::OP_CN_G:  cn_next  = 33'(p_reg) + prod[44:12];
                    sfl_pkg::OP_WP_CP: tmp_next = prod[60:28];
                    sfl_pkg::OP_Y_A:   ta_next  = prod[60:28];
                    sfl_pkg::OP_WN_CN: tmp_next = prod[60:28];
                    sfl_pkg::OP_YN_B:  tb_next  = prod[60:28];
                    sfl_pkg::OP_GRAD:  grad_next = grad_val;
                    sfl_pkg::OP_WP_NP: tmp_next = prod[60:28];
                    sfl_pkg::OP_Y_LP:  lacc_next = prod[60:28];
                    sfl_pkg::OP_WN_NQ: tmp_next = prod[60:28];
                    sfl_pkg::OP_YN_LQ: begin
                        eloss_next = eloss_val;
                        sum_next   = s_add[SW] ? {SW{1'b1}} : s_add[SW-1:0];
                        batch_next = '0;
                        done_next  = 1'b0;
                    end
                    sfl_pkg::OP_BL_LO: tmp_next = 33'((prod + RND24) >> 24);
                    sfl_pkg::OP_BL_HI: begin
                        batch_next = (b_sum > B_MAX) ? BW'(B_MAX) : BW'(b_sum);
                        done_next  = 1'b1;
                        sum_next   = '0;
                    end
                    default: op_next = op_reg;
                endcase
            end
            default: begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfl_pkg::ST_IDLE;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;       q_reg <= q_next;       y_reg <= y_next;     yn_reg <= yn_next;
        last_reg <= last_next; sel_reg <= sel_next;   m_reg <= m_next;     k_reg <= k_next;
        cnt_reg <= cnt_next;   lg_reg <= lg_next;     lp_reg <= lp_next;   lq_reg <= lq_next;
        np_reg <= np_next;     nq_reg <= nq_next;     t_reg <= t_next;     r_reg <= r_next;
        wp_reg <= wp_next;     wn_reg <= wn_next;     cp_reg <= cp_next;   cn_reg <= cn_next;
        tmp_reg <= tmp_next;   ta_reg <= ta_next;     tb_reg <= tb_next;   lacc_reg <= lacc_next;
        op_reg <= op_next;     grad_reg <= grad_next; eloss_reg <= eloss_next;
        batch_reg <= batch_next; done_reg <= done_next;
    end

    assign out_grad  = grad_reg;
    assign out_eloss = eloss_reg;
    assign out_batch = batch_reg;
    assign out_done  = done_reg;

endmodule
`default_nettype wire

FILE: rtl/sigmoid_focal_loss_gradient.sv
// Top level: config registers, core sequencer and result output register.
//
//  Channel | Dir | tdata fields (low bit up)                 | tlast
//  s_      | in  | probability, target                       | last
//  m_      | out | gradient, element_loss, batch_loss        | batch_done
//  cfg_    | in  | index 0 gamma, 1 grad_scale, 2 loss_scale | -
//
// A beat runs normalize (kp, kq: normalize shifts of p and 1-p, kp + kq between
// 2 and FRAC_BITS + 1), log squaring, powers and the multiply program, plus the
// batch-loss multiplies on a tlast beat, all on the single 33x33 multiplier.
// Reset (aresetn low, synchronous) restores config and control regs, clears the loss sum.
// s_tready is high only while the core is idle; a finished result waits in the
// output register while the next beat is already accepted.
`default_nettype none
module sigmoid_focal_loss_gradient #(
    parameter int FRAC_BITS         = 16,
    parameter int MAX_ELEMENTS_LOG2 = 20
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // probability, target
    input  wire logic [((2*FRAC_BITS+1+7)/8)*8-1:0]       s_tdata,
    input  wire logic                                     s_tlast,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // gradient, element_loss, batch_loss
    output logic      [((3*FRAC_BITS+46+7)/8)*8-1:0]      m_tdata,
    output logic                                          m_tlast,
    input  wire logic                                     cfg_wr_en,
    input  wire logic [1:0]                               cfg_addr,
    input  wire logic [24:0]                              cfg_wdata
);

    localparam int F      = FRAC_BITS;
    localparam int GW     = F + 9;
    localparam int EW     = F + 5;
    localparam int BW     = F + 32;
    localparam int OUT_TW = ((3*F + 46 + 7) / 8) * 8;

    sfl_pkg::cfg_t cfg_reg, cfg_next;

    logic          core_out_valid, core_out_ready, core_done;
    logic [GW-1:0] core_grad;
    logic [EW-1:0] core_eloss;
    logic [BW-1:0] core_batch;

    logic          m_valid_reg, m_valid_next;
    logic [GW-1:0] grad_reg, grad_next;
    logic [EW-1:0] eloss_reg, eloss_next;
    logic [BW-1:0] batch_reg, batch_next;
    logic          done_reg, done_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (sfl_pkg::cfg_idx_t'(cfg_addr))
                sfl_pkg::CFG_GAMMA:      cfg_next.gamma      = cfg_wdata[15:0];
                sfl_pkg::CFG_GRAD_SCALE: cfg_next.grad_scale = cfg_wdata;
                sfl_pkg::CFG_LOSS_SCALE: cfg_next.loss_scale = cfg_wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    sfl_core #(
        .FRAC_BITS         (FRAC_BITS),
        .MAX_ELEMENTS_LOG2 (MAX_ELEMENTS_LOG2)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_prob   (s_tdata[F-1:0]),
        .in_targ   (s_tdata[2*F:F]),
        .in_last   (s_tlast),
        .out_valid (core_out_valid),
        .out_ready (core_out_ready),
        .out_grad  (core_grad),
        .out_eloss (core_eloss),
        .out_batch (core_batch),
        .out_done  (core_done)
    );

    // output register takes a result when empty or emptying this cycle
    assign core_out_ready = core_out_valid && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        grad_next    = grad_reg;
        eloss_next   = eloss_reg;
        batch_next   = batch_reg;
        done_next    = done_reg;
        if (core_out_ready) begin
            m_valid_next = 1'b1;
            grad_next    = core_grad;
            eloss_next   = core_eloss;
            batch_next   = core_batch;
            done_next    = core_done;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gamma      <= 16'd8192;
            cfg_reg.grad_scale <= 25'd16777216;
            cfg_reg.loss_scale <= 25'd16777216;
            m_valid_reg        <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grad_reg  <= grad_next;
        eloss_reg <= eloss_next;
        batch_reg <= batch_next;
        done_reg  <= done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'({batch_reg, eloss_reg, grad_reg});
    assign m_tlast  = done_reg;

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for sigmoid_focal_loss_gradient: directed and random stream traffic checked by a focal-loss predictor.
`timescale 1ns / 1ps
module tb;

    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam int          FB = 16;
    localparam int          QB = 28;
    localparam logic [63:0] UNIT = 64'd1 << QB;
    localparam logic [63:0] LN2 = 64'd186065280;

    typedef struct {
        logic [24:0] gradient;
        logic [20:0] element_loss;
        logic [47:0] batch_loss;
        logic        batch_done;
    } focal_result_t;

    class focal_scoreboard;
        logic [63:0]   pow_tab [0:QB];
        logic [63:0]   gamma, grad_scale, loss_scale, loss_sum;
        focal_result_t pending_q [$];
        int            errors;

        function new();
            gamma = 8192;
            grad_scale = 64'd1 << 24;
            loss_scale = 64'd1 << 24;
            loss_sum = 0;
            errors = 0;
            pow_tab[0] = UNIT;
            pow_tab[1] = floor_sqrt((UNIT >> 1) << QB);
            for (int i = 2; i <= QB; i++) pow_tab[i] = floor_sqrt(pow_tab[i-1] << QB);
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] r, c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        function logic [63:0] rnd(logic [63:0] v, int s);
            return (v + (64'd1 << (s - 1))) >> s;
        endfunction

        // -log2(x), Q28, by normalize and repeated squaring
        function logic [63:0] minus_log2(logic [63:0] x);
            logic [63:0] m, y;
            int k;
            m = x;
            y = 0;
            k = 0;
            while (m < UNIT && k < 64) begin
                m = m << 1;
                k++;
            end
            for (int i = 1; i <= QB; i++) begin
                m = (m * m) >> QB;
                if (m >= (UNIT << 1)) begin
                    m = m >> 1;
                    y |= 64'd1 << (QB - i);
                end
            end
            return (64'(k) << QB) - y;
        endfunction

        function logic [63:0] exp2_neg(logic [63:0] t);
            logic [63:0] n, f, r;
            n = t >> QB;
            f = t & (UNIT - 1);
            r = UNIT;
            if (n > QB) return 0;
            for (int i = 1; i <= QB; i++)
                if (f[QB - i]) r = rnd(r * pow_tab[i], QB);
            return r >> n;
        endfunction

        function logic [63:0] qm(logic [63:0] a, logic [63:0] b);
            return (a * b) >> QB;
        endfunction

        function logic [63:0] gm(logic [63:0] a);
            return (a * gamma) >> 12;
        endfunction

        function void write_reg(logic [1:0] idx, logic [24:0] val);
            case (idx)
                sfl_pkg::CFG_GAMMA:      gamma = val[15:0];
                sfl_pkg::CFG_GRAD_SCALE: grad_scale = val;
                sfl_pkg::CFG_LOSS_SCALE: loss_scale = val;
                default: ;
            endcase
        endfunction

        function void note_input(logic [15:0] prob, logic [16:0] tgt, logic last);
            logic [63:0] p, q, y, yn, lp, lq, np, nq, wp, wn, cp, cn, a, b, mag, g, loss, el;
            logic [63:0] bl;
            focal_result_t r;
            p = (prob == 0 ? 64'd1 : 64'(prob)) << (QB - FB);
            q = UNIT - p;
            y = (tgt > 17'h10000 ? 64'h10000 : 64'(tgt)) << (QB - FB);
            yn = UNIT - y;
            lp = minus_log2(p);
            lq = minus_log2(q);
            np = rnd(lp * LN2, QB);
            nq = rnd(lq * LN2, QB);
            wp = exp2_neg(gm(lq));
            wn = exp2_neg(gm(lp));
            cp = q + gm(qm(p, np));
            cn = p + gm(qm(q, nq));
            a = qm(y, qm(wp, cp));
            b = qm(yn, qm(wn, cn));
            mag = (a > b) ? a - b : b - a;
            g = rnd(mag * grad_scale, 24 + QB - FB);
            if (a > b) begin
                if (g > (64'd1 << 24)) g = 64'd1 << 24;
                r.gradient = 25'(~g + 1);
            end else begin
                if (g > 64'hFF_FFFF) g = 64'hFF_FFFF;
                r.gradient = 25'(g);
            end
            loss = qm(y, qm(wp, np)) + qm(yn, qm(wn, nq));
            el = rnd(loss, QB - FB);
            if (el > 64'h1F_FFFF) el = 64'h1F_FFFF;
            r.element_loss = 21'(el);
            loss_sum += el;
            if (loss_sum > (64'd1 << 41) - 1) loss_sum = (64'd1 << 41) - 1;
            r.batch_done = last;
            r.batch_loss = 0;
            if (last) begin
                bl = (loss_sum >> 24) * loss_scale
                     + rnd((loss_sum & 64'hFF_FFFF) * loss_scale, 24);
                if (bl > (64'd1 << 48) - 1) bl = (64'd1 << 48) - 1;
                r.batch_loss = 48'(bl);
                loss_sum = 0;
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(logic [95:0] data, logic tlast);
            focal_result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", data);
                return;
            end
            e = pending_q.pop_front();
            if (data[24:0] !== e.gradient || data[45:25] !== e.element_loss
                    || data[93:46] !== e.batch_loss || tlast !== e.batch_done) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp grad %h eloss %h bloss %h done %b, got %h %h %h %b",
                             e.gradient, e.element_loss, e.batch_loss, e.batch_done,
                             data[24:0], data[45:25], data[93:46], tlast);
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [39:0] s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [95:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [24:0] cfg_wdata;
    bit          no_idle;

    focal_scoreboard sb = new();

    sigmoid_focal_loss_gradient i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata[15:0], s_tdata[32:16], s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        m_tready <= no_idle || ($urandom_range(99) >= 17);
    end

    task automatic send_beat(logic [15:0] prob, logic [16:0] tgt, logic last);
        if (!no_idle && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, tgt, prob};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // drives a config write, then drops the enable before returning so back-to-back writes never collide
    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // random batches; mostly valid targets, a few over 1.0
    task automatic random_batches(int n);
        int left;
        logic [16:0] tgt;
        left = 0;
        for (int i = 0; i < n; i++) begin
            if (left == 0) left = $urandom_range(1, 20);
            left--;
            tgt = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
            send_beat(16'($urandom), tgt, left == 0 || i == n - 1);
        end
    endtask

    initial begin
        aclk = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        no_idle = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: clamp edges, target saturation, batch ends
        send_beat(16'h0000, 17'h00000, 1'b0);
        send_beat(16'hFFFF, 17'h10000, 1'b0);
        send_beat(16'h0001, 17'h10000, 1'b0);
        send_beat(16'hFFFE, 17'h00000, 1'b1);
        send_beat(16'h8000, 17'h08000, 1'b0);
        send_beat(16'h0000, 17'h10000, 1'b0);
        send_beat(16'hFFFF, 17'h00000, 1'b0);
        send_beat(16'h4000, 17'h1FFFF, 1'b0);
        send_beat(16'hC000, 17'h10001, 1'b1);
        send_beat(16'h5555, 17'h0AAAA, 1'b1);
        drain();

        write_reg(sfl_pkg::CFG_GAMMA, 25'd0);
        write_reg(sfl_pkg::CFG_GRAD_SCALE, 25'd16777216);
        write_reg(sfl_pkg::CFG_LOSS_SCALE, 25'd16777216);
        send_beat(16'h0000, 17'h10000, 1'b0);
        send_beat(16'hFFFF, 17'h00000, 1'b1);
        random_batches(80);
        drain();

        write_reg(sfl_pkg::CFG_GAMMA, 25'h1FFFFFF);
        write_reg(sfl_pkg::CFG_GRAD_SCALE, 25'd0);
        write_reg(sfl_pkg::CFG_LOSS_SCALE, 25'd0);
        write_reg(CFG_UNUSED, 25'h155_5555);
        send_beat(16'h0001, 17'h00000, 1'b0);
        send_beat(16'hFFFF, 17'h10000, 1'b1);
        random_batches(70);
        drain();

        // scales above 1.0 push the outputs into saturation
        write_reg(sfl_pkg::CFG_GAMMA, 25'd16384);
        write_reg(sfl_pkg::CFG_GRAD_SCALE, 25'h1FFFFFF);
        write_reg(sfl_pkg::CFG_LOSS_SCALE, 25'h1FFFFFF);
        no_idle = 1;
        random_batches(80);
        no_idle = 0;
        drain();

        write_reg(sfl_pkg::CFG_GAMMA, 25'($urandom_range(65535)));
        write_reg(sfl_pkg::CFG_GRAD_SCALE, 25'($urandom_range(16777216)));
        write_reg(sfl_pkg::CFG_LOSS_SCALE, 25'($urandom_range(16777216)));
        random_batches(90);
        drain();

        write_reg(sfl_pkg::CFG_GAMMA, 25'd8192);
        write_reg(sfl_pkg::CFG_GRAD_SCALE, 25'd16777216);
        write_reg(sfl_pkg::CFG_LOSS_SCALE, 25'd8388608);
        random_batches(80);
        drain();

        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
